>>> rtl/svpwm_pkg.sv
// svpwm_pkg: field widths, register indexes, sector codes and the sine table
// shared by the space-vector modulator files; depends on nothing
package svpwm_pkg;

  localparam int COUNT_W = 14;
  localparam int CMP_W   = 12;
  localparam int CODE_W  = 3;
  localparam int REG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int SIN_W   = 16;
  // magnitude of a selected phase voltage, 15 fractional bits
  localparam int X_W     = 34;

  localparam int DEF_PWM_PERIOD     = 4096;
  localparam int DEF_ENCODER_COUNTS = 16384;
  localparam int DEF_POLE_PAIRS     = 10;

  localparam logic [IDX_W-1:0] REG_VOLTAGE_D   = 2'd0;
  localparam logic [IDX_W-1:0] REG_VOLTAGE_Q   = 2'd1;
  localparam logic [IDX_W-1:0] REG_BUS_VOLTAGE = 2'd2;

  localparam logic signed [REG_W-1:0] RST_VOLTAGE_D   = 16'sd0;
  localparam logic signed [REG_W-1:0] RST_VOLTAGE_Q   = 16'sd256;
  localparam logic        [REG_W-1:0] RST_BUS_VOLTAGE = 16'd3072;

  localparam logic [15:0] SQRT3_HALF_Q15 = 16'd28378;
  localparam logic [15:0] SQRT3_Q15      = 16'd56756;

  // sector codes: bit0 a>0, bit1 b>0, bit2 c>0
  localparam logic [CODE_W-1:0] SEC_NONE = 3'd0;
  localparam logic [CODE_W-1:0] SEC_A    = 3'd1;
  localparam logic [CODE_W-1:0] SEC_B    = 3'd2;
  localparam logic [CODE_W-1:0] SEC_AB   = 3'd3;
  localparam logic [CODE_W-1:0] SEC_C    = 3'd4;
  localparam logic [CODE_W-1:0] SEC_AC   = 3'd5;
  localparam logic [CODE_W-1:0] SEC_BC   = 3'd6;
  localparam logic [CODE_W-1:0] SEC_ALL  = 3'd7;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CMP_W-1:0]  ca;
    logic [CMP_W-1:0]  cb;
    logic [CMP_W-1:0]  cc;
    logic              over;
  } result_t;

  function automatic logic [SIN_W-1:0] quarter_sine(input logic [6:0] r);
    logic [SIN_W-1:0] v;
    case (r)
      7'd0: v = 16'd0;      7'd1: v = 16'd804;    7'd2: v = 16'd1608;   7'd3: v = 16'd2410;
      7'd4: v = 16'd3212;   7'd5: v = 16'd4011;   7'd6: v = 16'd4808;   7'd7: v = 16'd5602;
      7'd8: v = 16'd6393;   7'd9: v = 16'd7179;   7'd10: v = 16'd7962;  7'd11: v = 16'd8739;
      7'd12: v = 16'd9512;  7'd13: v = 16'd10278; 7'd14: v = 16'd11039; 7'd15: v = 16'd11793;
      7'd16: v = 16'd12539; 7'd17: v = 16'd13279; 7'd18: v = 16'd14010; 7'd19: v = 16'd14732;
      7'd20: v = 16'd15446; 7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17530;
      7'd24: v = 16'd18204; 7'd25: v = 16'd18868; 7'd26: v = 16'd19519; 7'd27: v = 16'd20159;
      7'd28: v = 16'd20787; 7'd29: v = 16'd21403; 7'd30: v = 16'd22005; 7'd31: v = 16'd22594;
      7'd32: v = 16'd23170; 7'd33: v = 16'd23731; 7'd34: v = 16'd24279; 7'd35: v = 16'd24811;
      7'd36: v = 16'd25329; 7'd37: v = 16'd25832; 7'd38: v = 16'd26319; 7'd39: v = 16'd26790;
      7'd40: v = 16'd27245; 7'd41: v = 16'd27683; 7'd42: v = 16'd28105; 7'd43: v = 16'd28510;
      7'd44: v = 16'd28898; 7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29956;
      7'd48: v = 16'd30273; 7'd49: v = 16'd30571; 7'd50: v = 16'd30852; 7'd51: v = 16'd31113;
      7'd52: v = 16'd31356; 7'd53: v = 16'd31580; 7'd54: v = 16'd31785; 7'd55: v = 16'd31971;
      7'd56: v = 16'd32137; 7'd57: v = 16'd32285; 7'd58: v = 16'd32412; 7'd59: v = 16'd32521;
      7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32728; 7'd63: v = 16'd32757;
      7'd64: v = 16'd32767;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [SIN_W-1:0] table_sine(input logic [7:0] idx);
    logic [6:0] r;
    logic [SIN_W-1:0] m;
    r = {1'b0, idx[5:0]};
    if (idx[6]) begin
      m = quarter_sine(7'd64 - r);
    end else begin
      m = quarter_sine(r);
    end
    if (idx[7]) begin
      return -$signed(m);
    end
    return $signed(m);
  endfunction

endpackage

>>> rtl/svpwm_if.sv
// svpwm_if: request channels of the modulator, encoder samples in and
// compare results out; depends on svpwm_pkg
interface svpwm_in_if;
  logic                          valid;
  logic                          ready;
  logic [svpwm_pkg::COUNT_W-1:0] encoder_count;
  modport source (output valid, output encoder_count, input ready);
  modport sink (input valid, input encoder_count, output ready);
endinterface

interface svpwm_out_if;
  logic                         valid;
  logic                         ready;
  logic [svpwm_pkg::CODE_W-1:0] sector_code;
  logic [svpwm_pkg::CMP_W-1:0]  compare_a;
  logic [svpwm_pkg::CMP_W-1:0]  compare_b;
  logic [svpwm_pkg::CMP_W-1:0]  compare_c;
  logic                         overmodulated;
  modport source (output valid, output sector_code, output compare_a, output compare_b,
                  output compare_c, output overmodulated, input ready);
  modport sink (input valid, input sector_code, input compare_a, input compare_b,
                input compare_c, input overmodulated, output ready);
endinterface

>>> rtl/svpwm_modulator.sv
// Space-vector PWM modulator: one encoder count in, sector code and three centered
// compare values out. A new count is taken every cycle while the skid entry is empty.
// Most of the pipeline is the two bit-per-stage dividers, vector time over bus
// voltage and the overmodulation rescale. The angle index comes from a reciprocal
// multiply. The d/q and bus registers are read live, so write them only while no
// request is in flight.
// An output register with one skid entry absorbs one result during an output stall;
// once the skid entry is full the pipeline and the input wait until it drains.
// No clearing pass. Depends on svpwm_pkg, svpwm_if and svpwm_div.
module svpwm_modulator #(
  parameter int PWM_PERIOD     = svpwm_pkg::DEF_PWM_PERIOD,
  parameter int ENCODER_COUNTS = svpwm_pkg::DEF_ENCODER_COUNTS,
  parameter int POLE_PAIRS     = svpwm_pkg::DEF_POLE_PAIRS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  svpwm_in_if.sink                      in_chan,
  svpwm_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [svpwm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [svpwm_pkg::REG_W-1:0]   cfg_data
);

  localparam int PPW  = $clog2(POLE_PAIRS + 1);
  localparam int AW   = svpwm_pkg::COUNT_W + PPW + 8;
  localparam int ECL  = $clog2(ENCODER_COUNTS);
  localparam int RW   = AW + 1;
  localparam int MW   = AW - 8 + RW;
  localparam int RSH  = AW + ECL - 8;
  localparam int XW   = svpwm_pkg::X_W;
  localparam int UW   = XW + 1;
  localparam int P2W  = $clog2(2 * PWM_PERIOD + 1);
  localparam int TNW  = UW + P2W;
  localparam int SUMW = TNW + 1;
  localparam int SHW  = SUMW - 32;
  localparam int KW   = $clog2(SHW + 1);
  localparam int HW   = $clog2(PWM_PERIOD / 2 + 1);
  localparam int HQW  = HW + 16;
  localparam int SNW  = 32 + HW + 16;
  localparam int VW   = HQW + 12;
  localparam int CW   = svpwm_pkg::CODE_W;
  localparam int SSW  = CW + 1 + 2 * HQW;

  // ceil(2^(AW+ECL) / resolution), exact floor for numerators below 2^AW
  localparam longint unsigned RECIP_L =
    ((64'd1 << (AW + ECL)) + 64'(ENCODER_COUNTS) - 64'd1) / 64'(ENCODER_COUNTS);
  localparam logic [RW-1:0]  RECIP = RW'(RECIP_L);
  localparam logic [P2W-1:0] TWO_P = P2W'(2 * PWM_PERIOD);
  localparam logic [HW-1:0]  HALF_P = HW'(PWM_PERIOD / 2);
  localparam logic [HQW-1:0] HQ = {HALF_P, 16'd0};
  localparam logic [svpwm_pkg::CMP_W-1:0] MID = svpwm_pkg::CMP_W'(PWM_PERIOD / 2);

  // configuration
  logic signed [svpwm_pkg::REG_W-1:0] vd_r, vq_r;
  logic        [svpwm_pkg::REG_W-1:0] bus_r;
  logic        [svpwm_pkg::REG_W-1:0] bus_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r  <= svpwm_pkg::RST_VOLTAGE_D;
      vq_r  <= svpwm_pkg::RST_VOLTAGE_Q;
      bus_r <= svpwm_pkg::RST_BUS_VOLTAGE;
    end else if (cfg_we) begin
      case (cfg_index)
        svpwm_pkg::REG_VOLTAGE_D:   vd_r  <= $signed(cfg_data);
        svpwm_pkg::REG_VOLTAGE_Q:   vq_r  <= $signed(cfg_data);
        svpwm_pkg::REG_BUS_VOLTAGE: bus_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bus_eff = (bus_r == '0) ? svpwm_pkg::REG_W'(1) : bus_r;

  // flow control
  logic en;
  logic skid_vld_r, out_vld_r;
  svpwm_pkg::result_t skid_r, out_r, res_r, res_nxt;

  assign en            = !skid_vld_r;
  assign in_chan.ready = en;

  // stage 1: electrical angle product
  logic              s1_vld_r;
  logic [AW-9:0]     prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (AW-8)'(in_chan.encoder_count) * (AW-8)'(POLE_PAIRS);
    end
  end

  // angle scale: product times reciprocal, table index is the quotient mod 256
  logic              sa_vld_r;
  logic [MW-1:0]     ang_r;
  logic [7:0]        aidx, cidx;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= MW'(prod_r) * MW'(RECIP);
    end
  end

  assign aidx = ang_r[RSH +: 8];
  assign cidx = aidx + 8'd64;

  // stage 2: sine and cosine
  logic                                s2_vld_r;
  logic signed [svpwm_pkg::SIN_W-1:0]  sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= svpwm_pkg::table_sine(aidx);
      cos_r <= svpwm_pkg::table_sine(cidx);
    end
  end

  // stage 3: inverse park products
  logic               s3_vld_r;
  logic signed [31:0] p_dc_r, p_qs_r, p_ds_r, p_qc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_dc_r <= vd_r * cos_r;
      p_qs_r <= vq_r * sin_r;
      p_ds_r <= vd_r * sin_r;
      p_qc_r <= vq_r * cos_r;
    end
  end

  // stage 4: alpha and beta
  logic               s4_vld_r;
  logic signed [32:0] alpha_r, beta_r;

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= 33'(p_dc_r) - 33'(p_qs_r);
      beta_r  <= 33'(p_ds_r) + 33'(p_qc_r);
    end
  end

  // stage 5: inverse clarke products
  logic               s5_vld_r;
  logic signed [48:0] bm_r, am_r;
  logic signed [32:0] pa5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bm_r  <= 49'(beta_r) * $signed({33'd0, svpwm_pkg::SQRT3_HALF_Q15});
      am_r  <= 49'(alpha_r) <<< 14;
      pa5_r <= alpha_r;
    end
  end

  // stage 6: phase voltages and sector code
  logic               s6_vld_r;
  logic signed [32:0] pa_r;
  logic signed [33:0] pb_r, pc_r;
  logic [CW-1:0]      code6_r;
  logic signed [48:0] db_nxt, dc_nxt;
  logic signed [33:0] pb_nxt, pc_nxt;

  always_comb begin
    db_nxt = bm_r - am_r;
    dc_nxt = -bm_r - am_r;
    pb_nxt = db_nxt[48:15];
    pc_nxt = dc_nxt[48:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r    <= pa5_r;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
      code6_r <= {(!pc_nxt[33] && (pc_nxt != '0)), (!pb_nxt[33] && (pb_nxt != '0)),
                  (!pa5_r[32] && (pa5_r != '0))};
    end
  end

  // stage 7: active vector pair
  logic               s7_vld_r;
  logic [XW-1:0]      x1_r, x2_r;
  logic [CW-1:0]      code7_r;
  logic signed [XW:0] a_e, b_e, c_e, x1_nxt, x2_nxt;

  always_comb begin
    a_e = (XW+1)'(pa_r);
    b_e = (XW+1)'(pb_r);
    c_e = (XW+1)'(pc_r);
    case (code6_r)
      svpwm_pkg::SEC_AB: begin x1_nxt = b_e;  x2_nxt = a_e;  end
      svpwm_pkg::SEC_A:  begin x1_nxt = -b_e; x2_nxt = -c_e; end
      svpwm_pkg::SEC_AC: begin x1_nxt = a_e;  x2_nxt = c_e;  end
      svpwm_pkg::SEC_C:  begin x1_nxt = -a_e; x2_nxt = -b_e; end
      svpwm_pkg::SEC_BC: begin x1_nxt = c_e;  x2_nxt = b_e;  end
      svpwm_pkg::SEC_B:  begin x1_nxt = -c_e; x2_nxt = -a_e; end
      default:           begin x1_nxt = '0;   x2_nxt = '0;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt[XW-1:0];
      x2_r    <= x2_nxt[XW-1:0];
      code7_r <= code6_r;
    end
  end

  // stage 8: times sqrt3
  logic             s8_vld_r;
  logic [UW-1:0]    u1_r, u2_r;
  logic [CW-1:0]    code8_r;
  logic [XW+15:0]   m1_nxt, m2_nxt;

  always_comb begin
    m1_nxt = (XW+16)'(x1_r) * (XW+16)'(svpwm_pkg::SQRT3_Q15);
    m2_nxt = (XW+16)'(x2_r) * (XW+16)'(svpwm_pkg::SQRT3_Q15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r    <= m1_nxt[XW+15:15];
      u2_r    <= m2_nxt[XW+15:15];
      code8_r <= code7_r;
    end
  end

  // stage 9: times twice the period
  logic                  s9_vld_r;
  logic [1:0][TNW-1:0]   tn_r;
  logic [CW-1:0]         code9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tn_r[0] <= TNW'(u1_r) * TNW'(TWO_P);
      tn_r[1] <= TNW'(u2_r) * TNW'(TWO_P);
      code9_r <= code8_r;
    end
  end

  // vector times over bus voltage
  logic                 td_vld;
  logic [1:0][TNW-1:0]  td_quo;
  logic [CW-1:0]        td_code;

  svpwm_div #(.NW(TNW), .DW(svpwm_pkg::REG_W), .LANES(2), .SW(CW)) u_time_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s9_vld_r), .num(tn_r), .den(bus_eff),
    .side(code9_r), .out_valid(td_vld), .quo(td_quo), .out_side(td_code)
  );

  // stage 10: sum, overmodulation test, normalizing shift
  logic              s10_vld_r;
  logic [TNW-1:0]    t1_r, t2_r;
  logic [SUMW-1:0]   sum_r, sum_nxt;
  logic              over10_r;
  logic [KW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     code10_r;

  always_comb begin
    sum_nxt = SUMW'(td_quo[0]) + SUMW'(td_quo[1]);
    k_nxt   = '0;
    for (int i = 0; i < SHW; i++) begin
      if (sum_nxt[32+i]) begin
        k_nxt = KW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= td_quo[0];
      t2_r     <= td_quo[1];
      sum_r    <= sum_nxt;
      over10_r <= sum_nxt > SUMW'(HQ);
      k_r      <= k_nxt;
      code10_r <= td_code;
    end
  end

  // stage 11: shift into 32 bits
  logic             s11_vld_r;
  logic [31:0]      ts1_r, ts2_r, sums_r;
  logic [HQW-1:0]   tb1_11_r, tb2_11_r;
  logic             over11_r;
  logic [CW-1:0]    code11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ts1_r    <= 32'(t1_r >> k_r);
      ts2_r    <= 32'(t2_r >> k_r);
      sums_r   <= 32'(sum_r >> k_r);
      tb1_11_r <= t1_r[HQW-1:0];
      tb2_11_r <= t2_r[HQW-1:0];
      over11_r <= over10_r;
      code11_r <= code10_r;
    end
  end

  // stage 12: rescale numerators
  logic                 s12_vld_r;
  logic [1:0][SNW-1:0]  sn_r;
  logic [31:0]          sden_r;
  logic [SSW-1:0]       sside_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0] <= {(32+HW)'(ts1_r) * (32+HW)'(HALF_P), 16'd0};
      sn_r[1] <= {(32+HW)'(ts2_r) * (32+HW)'(HALF_P), 16'd0};
      sden_r  <= sums_r;
      sside_r <= {code11_r, over11_r, tb1_11_r, tb2_11_r};
    end
  end

  logic                 sd_vld;
  logic [1:0][SNW-1:0]  sd_quo;
  logic [SSW-1:0]       sd_side;

  svpwm_div #(.NW(SNW), .DW(32), .LANES(2), .SW(SSW)) u_scale_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s12_vld_r), .num(sn_r), .den(sden_r),
    .side(sside_r), .out_valid(sd_vld), .quo(sd_quo), .out_side(sd_side)
  );

  // stage 13: final vector times and zero-vector share
  logic             s13_vld_r;
  logic [HQW-1:0]   t1f_r, t2f_r, v1_r;
  logic             over13_r;
  logic [CW-1:0]    code13_r;
  logic [HQW-1:0]   t1f_nxt, t2f_nxt;
  logic             sd_over;

  always_comb begin
    sd_over = sd_side[2*HQW];
    t1f_nxt = sd_over ? sd_quo[0][HQW-1:0] : sd_side[2*HQW-1:HQW];
    t2f_nxt = sd_over ? sd_quo[1][HQW-1:0] : sd_side[HQW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1f_r    <= t1f_nxt;
      t2f_r    <= t2f_nxt;
      v1_r     <= (HQ - t1f_nxt - t2f_nxt) >> 1;
      over13_r <= sd_over;
      code13_r <= sd_side[SSW-1:SSW-CW];
    end
  end

  // stage 14: compare values per sector
  logic           s14_vld_r;
  logic [VW-1:0]  v1e, v2e, v3e;
  logic [svpwm_pkg::CMP_W-1:0] k1, k2, k3;

  always_comb begin
    v1e = VW'(v1_r);
    v2e = v1e + VW'(t1f_r);
    v3e = v2e + VW'(t2f_r);
    k1  = v1e[16 +: svpwm_pkg::CMP_W];
    k2  = v2e[16 +: svpwm_pkg::CMP_W];
    k3  = v3e[16 +: svpwm_pkg::CMP_W];
    res_nxt.code = code13_r;
    res_nxt.over = over13_r;
    case (code13_r)
      svpwm_pkg::SEC_AB: begin res_nxt.ca = k1; res_nxt.cb = k2; res_nxt.cc = k3; end
      svpwm_pkg::SEC_A:  begin res_nxt.ca = k2; res_nxt.cb = k1; res_nxt.cc = k3; end
      svpwm_pkg::SEC_AC: begin res_nxt.ca = k3; res_nxt.cb = k1; res_nxt.cc = k2; end
      svpwm_pkg::SEC_C:  begin res_nxt.ca = k3; res_nxt.cb = k2; res_nxt.cc = k1; end
      svpwm_pkg::SEC_BC: begin res_nxt.ca = k2; res_nxt.cb = k3; res_nxt.cc = k1; end
      svpwm_pkg::SEC_B:  begin res_nxt.ca = k1; res_nxt.cb = k3; res_nxt.cc = k2; end
      default: begin
        res_nxt.ca   = MID;
        res_nxt.cb   = MID;
        res_nxt.cc   = MID;
        res_nxt.over = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // valid bits of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      sa_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
      s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0;
      s14_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_chan.valid;
      sa_vld_r  <= s1_vld_r;
      s2_vld_r  <= sa_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= td_vld;
      s11_vld_r <= s10_vld_r;
      s12_vld_r <= s11_vld_r;
      s13_vld_r <= sd_vld;
      s14_vld_r <= s13_vld_r;
    end
  end

  // output register with skid entry
  logic res_fire;
  assign res_fire = en && s14_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_chan.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= res_fire;
      end
    end else if (res_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_chan.ready || !out_vld_r) begin
      out_r <= skid_vld_r ? skid_r : res_r;
    end else if (res_fire) begin
      skid_r <= res_r;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.sector_code   = out_r.code;
  assign out_chan.compare_a     = out_r.ca;
  assign out_chan.compare_b     = out_r.cb;
  assign out_chan.compare_c     = out_r.cc;
  assign out_chan.overmodulated = out_r.over;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_no_all_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.code != svpwm_pkg::SEC_ALL))
    else $error("all three phase voltages positive");

  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.code == svpwm_pkg::SEC_NONE))
      |-> (out_r.ca == MID && out_r.cb == MID && out_r.cc == MID && !out_r.over))
    else $error("zero vector without centered compares");

  a_stall_holds_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_vld_r && !out_chan.ready) |=> (skid_vld_r && $stable(skid_r)))
    else $error("skid entry lost during output stall");
`endif

endmodule

>>> rtl/svpwm_div.sv
// svpwm_div: pipelined restoring divider, one quotient bit per stage, with
// lanes sharing one divisor and a sideband that travels along; no dependencies
module svpwm_div #(
  parameter int NW    = 32,
  parameter int DW    = 16,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [SW-1:0]              side,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   quo,
  output logic [SW-1:0]              out_side
);

  logic [LANES-1:0][DW-1:0] rem_r  [NW];
  logic [LANES-1:0][NW-1:0] nq_r   [NW];
  logic [DW-1:0]            den_r  [NW];
  logic [SW-1:0]            side_r [NW];
  logic                     vld_r  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_in;
    logic [LANES-1:0][NW-1:0] nq_in;
    logic [DW-1:0]            den_in;
    logic [SW-1:0]            side_in;
    logic                     vld_in;
    logic [LANES-1:0][DW-1:0] rem_nxt;
    logic [LANES-1:0][NW-1:0] nq_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num;
      assign den_in  = den;
      assign side_in = side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign nq_in   = nq_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // remainder shifts in the next numerator bit, quotient bit enters at the bottom
    always_comb begin
      logic [DW:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_in[l], nq_in[l][NW-1]};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt[l] = DW'(trial - {1'b0, den_in});
          nq_nxt[l]  = {nq_in[l][NW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[DW-1:0];
          nq_nxt[l]  = {nq_in[l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
      if (en) begin
        rem_r[i]  <= rem_nxt;
        nq_r[i]   <= nq_nxt;
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quo       = nq_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

>>> tb/sv/svpwm_checker.sv
`timescale 1ns / 100ps
// svpwm_checker: watches the encoder and compare channels and the register
// port of the modulator, predicts each result and compares it in order
// depends on svpwm_pkg and the channel interfaces in svpwm_if
module svpwm_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  svpwm_in_if                         in_ch,
  svpwm_out_if                        out_ch,
  input  logic                        cfg_we,
  input  logic [svpwm_pkg::IDX_W-1:0] cfg_index,
  input  logic [svpwm_pkg::REG_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count,
  output int                          overmod_count
);

  localparam longint unsigned HALF_TICKS = 64'd2048 << 16;
  localparam int QSIN [65] = '{
    0, 804, 1608, 2410, 3212, 4011, 4808, 5602, 6393, 7179, 7962, 8739,
    9512, 10278, 11039, 11793, 12539, 13279, 14010, 14732, 15446, 16151,
    16846, 17530, 18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
    23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790, 27245, 27683,
    28105, 28510, 28898, 29268, 29621, 29956, 30273, 30571, 30852, 31113,
    31356, 31580, 31785, 31971, 32137, 32285, 32412, 32521, 32609, 32678,
    32728, 32757, 32767};

  logic signed [svpwm_pkg::REG_W-1:0] volt_d, volt_q;
  logic [svpwm_pkg::REG_W-1:0]        volt_bus;
  svpwm_pkg::result_t                 expected_q[$];

  function automatic longint sine_at(int step);
    int quad, r;
    quad = (step >> 6) & 3;
    r = step & 63;
    case (quad)
      0: return QSIN[r];
      1: return QSIN[64 - r];
      2: return -QSIN[r];
      default: return -QSIN[64 - r];
    endcase
  endfunction

  function automatic longint unsigned ticks_of(longint x, longint unsigned bus);
    longint unsigned u;
    if (x < 0) x = 0;
    u = (longint'(x) * 56756) >> 15;
    return (u * 8192) / bus;
  endfunction

  function automatic svpwm_pkg::result_t predict_compares(
      logic [svpwm_pkg::COUNT_W-1:0] cnt);
    longint angle, sn, cs, alpha, beta, pa, pb, pc, x1, x2;
    longint unsigned bus, t1, t2, total, v1, v2, v3, ca, cb, cc;
    int step;
    logic [svpwm_pkg::CODE_W-1:0] code;
    logic over;
    svpwm_pkg::result_t r;
    angle = (longint'(cnt) * 10) % 16384;
    step = int'(angle >> 6) & 255;
    sn = sine_at(step);
    cs = sine_at((step + 64) & 255);
    alpha = longint'(volt_d) * cs - longint'(volt_q) * sn;
    beta = longint'(volt_d) * sn + longint'(volt_q) * cs;
    pa = alpha;
    pb = (beta * 28378 - alpha * 16384) >>> 15;
    pc = (-beta * 28378 - alpha * 16384) >>> 15;
    code = {pc > 0, pb > 0, pa > 0};
    bus = (volt_bus == 0) ? 1 : volt_bus;
    over = 1'b0;
    case (code)
      svpwm_pkg::SEC_AB: begin x1 = pb;  x2 = pa;  end
      svpwm_pkg::SEC_A:  begin x1 = -pb; x2 = -pc; end
      svpwm_pkg::SEC_AC: begin x1 = pa;  x2 = pc;  end
      svpwm_pkg::SEC_C:  begin x1 = -pa; x2 = -pb; end
      svpwm_pkg::SEC_BC: begin x1 = pc;  x2 = pb;  end
      svpwm_pkg::SEC_B:  begin x1 = -pc; x2 = -pa; end
      default:           begin x1 = 0;   x2 = 0;   end
    endcase
    t1 = ticks_of(x1, bus);
    t2 = ticks_of(x2, bus);
    if (t1 + t2 > HALF_TICKS) begin
      total = t1 + t2;
      while (total >= (64'd1 << 32)) begin
        total = total >> 1;
        t1 = t1 >> 1;
        t2 = t2 >> 1;
      end
      t1 = t1 * HALF_TICKS / total;
      t2 = t2 * HALF_TICKS / total;
      over = 1'b1;
    end
    v1 = (HALF_TICKS - t1 - t2) >> 1;
    v2 = v1 + t1;
    v3 = v2 + t2;
    v1 = v1 >> 16;
    v2 = v2 >> 16;
    v3 = v3 >> 16;
    case (code)
      svpwm_pkg::SEC_AB: begin ca = v1; cb = v2; cc = v3; end
      svpwm_pkg::SEC_A:  begin ca = v2; cb = v1; cc = v3; end
      svpwm_pkg::SEC_AC: begin ca = v3; cb = v1; cc = v2; end
      svpwm_pkg::SEC_C:  begin ca = v3; cb = v2; cc = v1; end
      svpwm_pkg::SEC_BC: begin ca = v2; cb = v3; cc = v1; end
      svpwm_pkg::SEC_B:  begin ca = v1; cb = v3; cc = v2; end
      default: begin
        ca = 2048; cb = 2048; cc = 2048;
        over = 1'b0;
      end
    endcase
    r.code = code;
    r.ca = ca[svpwm_pkg::CMP_W-1:0];
    r.cb = cb[svpwm_pkg::CMP_W-1:0];
    r.cc = cc[svpwm_pkg::CMP_W-1:0];
    r.over = over;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    svpwm_pkg::result_t got, want;
    if (!rst_n) begin
      volt_d <= svpwm_pkg::RST_VOLTAGE_D;
      volt_q <= svpwm_pkg::RST_VOLTAGE_Q;
      volt_bus <= svpwm_pkg::RST_BUS_VOLTAGE;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      overmod_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          svpwm_pkg::REG_VOLTAGE_D:   volt_d <= cfg_data;
          svpwm_pkg::REG_VOLTAGE_Q:   volt_q <= cfg_data;
          svpwm_pkg::REG_BUS_VOLTAGE: volt_bus <= cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_compares(in_ch.encoder_count));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sector_code, out_ch.compare_a, out_ch.compare_b,
                out_ch.compare_c, out_ch.overmodulated};
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result code=%0d a=%0d b=%0d c=%0d ovm=%0b", $time,
                   got.code, got.ca, got.cb, got.cc, got.over);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.over) overmod_count <= overmod_count + 1;
          if (got !== want) begin
            $display("%0t: mismatch expected code=%0d a=%0d b=%0d c=%0d ovm=%0b", $time,
                     want.code, want.ca, want.cb, want.cc, want.over);
            $display("%0t:          actual   code=%0d a=%0d b=%0d c=%0d ovm=%0b", $time,
                     got.code, got.ca, got.cb, got.cc, got.over);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives encoder requests, register settings and result stalls into
// svpwm_modulator; checking is done by svpwm_checker
// depends on svpwm_pkg, svpwm_if, svpwm_checker and the modulator RTL
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_PER_SET = 206;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [svpwm_pkg::IDX_W-1:0] cfg_index = svpwm_pkg::REG_VOLTAGE_D;
  logic [svpwm_pkg::REG_W-1:0] cfg_data = '0;
  int fail_count, pending, result_count, overmod_count;
  int sent = 0;
  int settings = 1;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  svpwm_in_if  in_ch ();
  svpwm_out_if out_ch ();

  svpwm_modulator dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_ch), .out_chan(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  svpwm_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .overmod_count(overmod_count)
  );

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_count(input logic [svpwm_pkg::COUNT_W-1:0] cnt);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.encoder_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic apply_setting(input logic [svpwm_pkg::REG_W-1:0] vd,
                               input logic [svpwm_pkg::REG_W-1:0] vq,
                               input logic [svpwm_pkg::REG_W-1:0] vbus);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= svpwm_pkg::REG_VOLTAGE_D;
    cfg_data <= vd;
    @(posedge clk);
    cfg_index <= svpwm_pkg::REG_VOLTAGE_Q;
    cfg_data <= vq;
    @(posedge clk);
    cfg_index <= svpwm_pkg::REG_BUS_VOLTAGE;
    cfg_data <= vbus;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_counts(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: send_count(svpwm_pkg::COUNT_W'($urandom_range(0, 15)) << 10 |
                      svpwm_pkg::COUNT_W'($urandom_range(0, 1)));
        default: send_count(svpwm_pkg::COUNT_W'($urandom_range(0, 16383)));
      endcase
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.encoder_count <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: limits of the count and a sweep over the electrical turn
    send_count(14'd0);
    send_count(14'd16383);
    send_count(14'd1);
    send_count(14'd8191);
    send_count(14'd8192);
    send_count(14'h2AAA);
    send_count(14'h1555);
    for (int k = 0; k < 13; k++) send_count(svpwm_pkg::COUNT_W'(k * 126));
    random_counts(RANDOM_PER_SET);

    apply_setting(16'h7FFF, 16'h7FFF, 16'd1);
    send_count(14'd0);
    send_count(14'd16383);
    random_counts(RANDOM_PER_SET);
    apply_setting(16'h8000, 16'h8000, 16'hFFFF);
    random_counts(RANDOM_PER_SET);
    apply_setting(16'h0000, 16'h0000, 16'd3072);
    random_counts(40);
    apply_setting(16'h8000, 16'h7FFF, 16'd0);
    random_counts(RANDOM_PER_SET);
    apply_setting(16'h0001, 16'hFFFF, 16'hFFFF);
    random_counts(RANDOM_PER_SET);
    for (int p = 0; p < 4; p++) begin
      apply_setting(svpwm_pkg::REG_W'($urandom), svpwm_pkg::REG_W'($urandom),
                    (p == 3) ? svpwm_pkg::REG_W'($urandom)
                             : svpwm_pkg::REG_W'($urandom_range(256, 8192)));
      random_counts(RANDOM_PER_SET);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d encoder requests over %0d register settings, %0d results checked",
             sent, settings, result_count);
    $display("%0d results expected overmodulated", overmod_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
